>>> rtl/core/kemcsr_pkg.sv
// ----------------------------------------------------------------------------
// kemcsr_pkg
// shared types and codes for the k-way edge merge to csr builder
// ----------------------------------------------------------------------------
package kemcsr_pkg;

  // width of the active_runs configuration register
  localparam int unsigned CfgW = 4;
  // reset value of active_runs
  localparam logic [CfgW-1:0] ACTIVE_RUNS_RST = 4'd8;

  // values for the 31-bit vertex fields and the 32-bit "none" markers
  localparam logic [31:0] NONE32  = 32'hFFFF_FFFF;
  localparam logic [30:0] DEG_MAX = 31'h7FFF_FFFF;

  // request command codes
  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_EXHAUST = 1'b1;

  // result kinds, also used as the op code between front and back
  typedef enum logic [1:0] {
    KIND_MERGE   = 2'd0,
    KIND_SUMMARY = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_e;

  typedef struct packed {
    logic        cmd;
    logic [2:0]  run;
    logic [30:0] src;
    logic [30:0] dst;
  } in_item_t;

  typedef struct packed {
    kind_e       kind;
    logic        neighbor_valid;
    logic [30:0] neighbor;
    logic        vertex_start;
    logic [31:0] vertex_offset;
    logic        prev_degree_valid;
    logic [30:0] prev_degree;
    logic [31:0] vertex_count;
    logic [31:0] edge_count;
    logic [30:0] peak_degree;
  } out_item_t;

  // one run head
  typedef struct packed {
    logic [30:0] src;
    logic [30:0] dst;
  } edge_t;

endpackage

>>> rtl/core/kemcsr_fifo.sv
// ----------------------------------------------------------------------------
// kemcsr_fifo
// small flop-based first-in first-out queue
// ----------------------------------------------------------------------------
module kemcsr_fifo #(
  parameter int unsigned Width = 2,
  parameter int unsigned Depth = 2,
  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1,
  localparam int unsigned CntW = $clog2(Depth + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             empty_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

>>> rtl/core/kemcsr_front.sv
// ----------------------------------------------------------------------------
// kemcsr_front
// accepts requests, tracks run slot flags and classifies each request
// ----------------------------------------------------------------------------
module kemcsr_front #(
  parameter int unsigned MAX_RUNS = 8,
  localparam int unsigned IdxW = $clog2(MAX_RUNS),
  localparam int unsigned CntW = $clog2(MAX_RUNS + 1)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // request side
  input  logic                       push,
  output logic                       full,
  input  kemcsr_pkg::in_item_t       item_i,
  // configuration
  input  logic                       cfg_we_i,
  input  logic [kemcsr_pkg::CfgW-1:0] cfg_wdata_i,
  // op queue
  output logic                       cmd_push_o,
  output kemcsr_pkg::kind_e          cmd_kind_o,
  input  logic                       cmd_full_i,
  // head memory write
  output logic                       hw_en_o,
  output logic [IdxW-1:0]            hw_idx_o,
  output kemcsr_pkg::edge_t          hw_data_o,
  // state seen by the back end
  output logic [MAX_RUNS-1:0]        full_vec_o,
  output logic [CntW-1:0]            run_count_o,
  input  logic                       clr_valid_i,
  input  logic [IdxW-1:0]            clr_idx_i
);

  logic [kemcsr_pkg::CfgW-1:0] active_runs_q;
  logic [MAX_RUNS-1:0]         full_q, full_d;
  logic [MAX_RUNS-1:0]         exh_q, exh_d;
  logic                        busy_q, busy_d;
  logic [MAX_RUNS-1:0]         act_mask;
  logic [MAX_RUNS-1:0]         f_nxt, e_nxt;
  logic [CntW-1:0]             run_count;
  logic [IdxW-1:0]             run_idx;
  logic                        accept, err, all_ready, any_full;

  // clamp active_runs into 1..MAX_RUNS
  always_comb begin
    if (active_runs_q == '0) begin
      run_count = CntW'(1);
    end else if (int'(active_runs_q) > int'(MAX_RUNS)) begin
      run_count = CntW'(MAX_RUNS);
    end else begin
      run_count = CntW'(active_runs_q);
    end
    for (int i = 0; i < int'(MAX_RUNS); i++) begin
      act_mask[i] = (i < int'(run_count));
    end
  end

  assign run_count_o = run_count;
  assign full_vec_o  = full_q;
  assign run_idx     = IdxW'(item_i.run);
  assign full        = busy_q || cmd_full_i;
  assign accept      = push && !full;
  assign err = (int'(item_i.run) >= int'(run_count)) || full_q[run_idx] || exh_q[run_idx];

  always_comb begin
    f_nxt = full_q;
    e_nxt = exh_q;
    if (item_i.cmd == kemcsr_pkg::CMD_LOAD) begin
      f_nxt[run_idx] = 1'b1;
    end else begin
      e_nxt[run_idx] = 1'b1;
    end
    all_ready = &(f_nxt | e_nxt | ~act_mask);
    any_full  = |(f_nxt & act_mask);
  end

  always_comb begin
    cmd_push_o = accept && (err || all_ready);
    if (err) begin
      cmd_kind_o = kemcsr_pkg::KIND_ERROR;
    end else if (any_full) begin
      cmd_kind_o = kemcsr_pkg::KIND_MERGE;
    end else begin
      cmd_kind_o = kemcsr_pkg::KIND_SUMMARY;
    end
  end

  assign hw_en_o       = accept && !err && (item_i.cmd == kemcsr_pkg::CMD_LOAD);
  assign hw_idx_o      = run_idx;
  assign hw_data_o.src = item_i.src;
  assign hw_data_o.dst = item_i.dst;

  always_comb begin
    full_d = full_q;
    exh_d  = exh_q;
    busy_d = busy_q;
    // a merge holds off new requests until its slot is freed
    if (clr_valid_i) begin
      full_d[clr_idx_i] = 1'b0;
      busy_d            = 1'b0;
    end
    if (accept && !err) begin
      full_d = f_nxt;
      exh_d  = e_nxt;
      if (all_ready && any_full) begin
        busy_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_runs_q <= kemcsr_pkg::ACTIVE_RUNS_RST;
      full_q        <= '0;
      exh_q         <= '0;
      busy_q        <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        active_runs_q <= cfg_wdata_i;
      end
      full_q <= full_d;
      exh_q  <= exh_d;
      busy_q <= busy_d;
    end
  end

endmodule

>>> rtl/core/kemcsr_back.sv
// ----------------------------------------------------------------------------
// kemcsr_back
// scans run heads, takes the smallest, keeps the csr counters and emits summaries and errors
// ----------------------------------------------------------------------------
module kemcsr_back #(
  parameter int unsigned MAX_RUNS = 8,
  localparam int unsigned IdxW = $clog2(MAX_RUNS),
  localparam int unsigned CntW = $clog2(MAX_RUNS + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // op queue
  input  logic                  cmd_empty_i,
  input  kemcsr_pkg::kind_e     cmd_kind_i,
  output logic                  cmd_pop_o,
  // head memory write
  input  logic                  hw_en_i,
  input  logic [IdxW-1:0]       hw_idx_i,
  input  kemcsr_pkg::edge_t     hw_data_i,
  // front state
  input  logic [MAX_RUNS-1:0]   full_vec_i,
  input  logic [CntW-1:0]       run_count_i,
  output logic                  clr_valid_o,
  output logic [IdxW-1:0]       clr_idx_o,
  // result
  output logic                  res_valid_o,
  output kemcsr_pkg::out_item_t res_o,
  input  logic                  res_ready_i
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_TAKE = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  kemcsr_pkg::edge_t     head_mem [MAX_RUNS];
  kemcsr_pkg::edge_t     rd_data_q;
  kemcsr_pkg::edge_t     best_q, best_d;
  kemcsr_pkg::out_item_t res_q, res_d;

  logic [1:0]      state_q, state_d;
  logic [CntW-1:0] scan_q, scan_d;
  logic [IdxW-1:0] rd_idx_q, rd_idx_d;
  logic            rd_vld_q, rd_vld_d;
  logic [IdxW-1:0] best_idx_q, best_idx_d;
  logic            best_vld_q, best_vld_d;
  logic [31:0]     last_src_q, last_src_d;
  logic [31:0]     last_dst_q, last_dst_d;
  logic [31:0]     open_q, open_d;
  logic [31:0]     nw_q, nw_d;
  logic [31:0]     degsum_q, degsum_d;
  logic [30:0]     largest_q, largest_d;
  logic            open_none, less, scan_more;
  logic [31:0]     sum_fold;
  logic [30:0]     mx_fold;

  // head slots, one read per cycle during the scan
  always_ff @(posedge clk_i) begin
    if (hw_en_i) begin
      head_mem[hw_idx_i] <= hw_data_i;
    end
    rd_data_q <= head_mem[scan_q[IdxW-1:0]];
  end

  assign open_none = (open_q == kemcsr_pkg::NONE32);
  assign sum_fold  = degsum_q + (open_none ? 32'd0 : open_q);
  assign mx_fold   = (!open_none && (open_q > {1'b0, largest_q})) ? open_q[30:0] : largest_q;
  assign scan_more = (scan_q < run_count_i);
  assign less = (rd_data_q.src < best_q.src) ||
                ((rd_data_q.src == best_q.src) && (rd_data_q.dst < best_q.dst));

  assign cmd_pop_o   = (state_q == ST_IDLE) && !cmd_empty_i;
  assign clr_valid_o = (state_q == ST_TAKE);
  assign clr_idx_o   = best_idx_q;
  assign res_valid_o = (state_q == ST_EMIT);
  assign res_o       = res_q;

  always_comb begin
    state_d    = state_q;
    scan_d     = scan_q;
    rd_idx_d   = rd_idx_q;
    rd_vld_d   = rd_vld_q;
    best_d     = best_q;
    best_idx_d = best_idx_q;
    best_vld_d = best_vld_q;
    res_d      = res_q;
    last_src_d = last_src_q;
    last_dst_d = last_dst_q;
    open_d     = open_q;
    nw_d       = nw_q;
    degsum_d   = degsum_q;
    largest_d  = largest_q;

    unique case (state_q)
      ST_IDLE: begin
        if (!cmd_empty_i) begin
          res_d = '0;
          unique case (cmd_kind_i)
            kemcsr_pkg::KIND_ERROR: begin
              res_d.kind = kemcsr_pkg::KIND_ERROR;
              state_d    = ST_EMIT;
            end
            kemcsr_pkg::KIND_SUMMARY: begin
              res_d.kind         = kemcsr_pkg::KIND_SUMMARY;
              res_d.vertex_count = last_src_q + 32'd1;
              res_d.edge_count   = {1'b0, sum_fold[31:1]};
              res_d.peak_degree  = mx_fold;
              state_d            = ST_EMIT;
            end
            kemcsr_pkg::KIND_MERGE: begin
              scan_d     = '0;
              rd_vld_d   = 1'b0;
              best_vld_d = 1'b0;
              state_d    = ST_SCAN;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_SCAN: begin
        // issue one read and compare the previous one each cycle
        rd_vld_d = scan_more;
        rd_idx_d = scan_q[IdxW-1:0];
        if (scan_more) begin
          scan_d = scan_q + CntW'(1);
        end
        if (rd_vld_q && full_vec_i[rd_idx_q] && (!best_vld_q || less)) begin
          best_d     = rd_data_q;
          best_idx_d = rd_idx_q;
          best_vld_d = 1'b1;
        end
        if (!scan_more && !rd_vld_q) begin
          state_d = ST_TAKE;
        end
      end
      ST_TAKE: begin
        res_d          = '0;
        res_d.kind     = kemcsr_pkg::KIND_MERGE;
        res_d.neighbor = best_q.dst;
        if ({1'b0, best_q.src} != last_src_q) begin
          // new source vertex: close the open one
          res_d.neighbor_valid = 1'b1;
          res_d.vertex_start   = 1'b1;
          res_d.vertex_offset  = nw_q;
          if (!open_none) begin
            res_d.prev_degree_valid = 1'b1;
            res_d.prev_degree       = open_q[30:0];
            degsum_d                = degsum_q + open_q;
            if (open_q > {1'b0, largest_q}) begin
              largest_d = open_q[30:0];
            end
          end
          open_d = 32'd1;
          nw_d   = nw_q + 32'd1;
        end else if ({1'b0, best_q.dst} != last_dst_q) begin
          res_d.neighbor_valid = 1'b1;
          if (open_none) begin
            open_d = 32'd1;
          end else if (open_q < {1'b0, kemcsr_pkg::DEG_MAX}) begin
            open_d = open_q + 32'd1;
          end
          nw_d = nw_q + 32'd1;
        end
        last_src_d = {1'b0, best_q.src};
        last_dst_d = {1'b0, best_q.dst};
        state_d    = ST_EMIT;
      end
      ST_EMIT: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      scan_q     <= '0;
      rd_vld_q   <= 1'b0;
      best_vld_q <= 1'b0;
      last_src_q <= kemcsr_pkg::NONE32;
      last_dst_q <= kemcsr_pkg::NONE32;
      open_q     <= kemcsr_pkg::NONE32;
      nw_q       <= '0;
      degsum_q   <= '0;
      largest_q  <= '0;
    end else begin
      state_q    <= state_d;
      scan_q     <= scan_d;
      rd_vld_q   <= rd_vld_d;
      best_vld_q <= best_vld_d;
      last_src_q <= last_src_d;
      last_dst_q <= last_dst_d;
      open_q     <= open_d;
      nw_q       <= nw_d;
      degsum_q   <= degsum_d;
      largest_q  <= largest_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q   <= rd_idx_d;
    best_q     <= best_d;
    best_idx_q <= best_idx_d;
    res_q      <= res_d;
  end

endmodule

>>> rtl/core/kway_edge_merge_csr_builder_unit.sv
// ----------------------------------------------------------------------------
// kway_edge_merge_csr_builder_unit
// k-way merge of sorted edge runs into csr adjacency records
// ----------------------------------------------------------------------------
// usage:
//   requests enter through push/full/item_i: each request loads the next
//   edge of one run into its head slot or marks the run exhausted.
//   results leave through empty/pop/result_o, oldest first; one merge step,
//   summary or error per request that completes a decision, none otherwise.
//   active_runs is written through cfg_we_i/cfg_wdata_i while idle.
// flow:
//   error and summary results pass through the op queue, the back end's
//   result register and the result queue. a merge step scans the n active
//   head slots one per cycle from the head memory read port. full stays
//   high from the accepting request until the taken slot is freed, so no
//   further request is taken while a merge step is in progress.
// reset:
//   all slots empty and not exhausted, no vertex open, counters cleared,
//   active_runs = 8; head slot contents are not cleared.
// stall:
//   when pop stays low the result queue fills, the back end waits and the
//   op queue then raises full toward the request side.
// ----------------------------------------------------------------------------
module kway_edge_merge_csr_builder_unit #(
  parameter int unsigned MAX_RUNS = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // request channel
  input  logic                        push,
  output logic                        full,
  input  kemcsr_pkg::in_item_t        item_i,
  // result channel
  output logic                        empty,
  input  logic                        pop,
  output kemcsr_pkg::out_item_t       result_o,
  // configuration
  input  logic                        cfg_we_i,
  input  logic [kemcsr_pkg::CfgW-1:0] cfg_wdata_i
);

  localparam int unsigned IdxW = $clog2(MAX_RUNS);
  localparam int unsigned CntW = $clog2(MAX_RUNS + 1);
  localparam int unsigned OpW  = $bits(kemcsr_pkg::kind_e);
  localparam int unsigned ResW = $bits(kemcsr_pkg::out_item_t);

  // front to op queue
  logic                  cmd_push, cmd_full, cmd_empty, cmd_pop;
  kemcsr_pkg::kind_e     cmd_kind_in;
  logic [OpW-1:0]        cmd_rdata;

  // front to back: head writes and slot state
  logic                  hw_en;
  logic [IdxW-1:0]       hw_idx;
  kemcsr_pkg::edge_t     hw_data;
  logic [MAX_RUNS-1:0]   full_vec;
  logic [CntW-1:0]       run_count;
  logic                  clr_valid;
  logic [IdxW-1:0]       clr_idx;

  // back to result queue
  logic                  res_valid, res_full;
  kemcsr_pkg::out_item_t res;
  logic [ResW-1:0]       res_rdata;

  kemcsr_front #(
    .MAX_RUNS(MAX_RUNS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .item_i      (item_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_push_o  (cmd_push),
    .cmd_kind_o  (cmd_kind_in),
    .cmd_full_i  (cmd_full),
    .hw_en_o     (hw_en),
    .hw_idx_o    (hw_idx),
    .hw_data_o   (hw_data),
    .full_vec_o  (full_vec),
    .run_count_o (run_count),
    .clr_valid_i (clr_valid),
    .clr_idx_i   (clr_idx)
  );

  // short op queue between classification and execution
  kemcsr_fifo #(
    .Width(OpW),
    .Depth(2)
  ) u_op_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .wdata_i (cmd_kind_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .rdata_o (cmd_rdata),
    .empty_o (cmd_empty)
  );

  kemcsr_back #(
    .MAX_RUNS(MAX_RUNS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_empty_i (cmd_empty),
    .cmd_kind_i  (kemcsr_pkg::kind_e'(cmd_rdata)),
    .cmd_pop_o   (cmd_pop),
    .hw_en_i     (hw_en),
    .hw_idx_i    (hw_idx),
    .hw_data_i   (hw_data),
    .full_vec_i  (full_vec),
    .run_count_i (run_count),
    .clr_valid_o (clr_valid),
    .clr_idx_o   (clr_idx),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_ready_i (!res_full)
  );

  // result queue decouples the back end from a stalled receiver
  kemcsr_fifo #(
    .Width(ResW),
    .Depth(2)
  ) u_res_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_valid),
    .wdata_i (res),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (res_rdata),
    .empty_o (empty)
  );

  assign result_o = kemcsr_pkg::out_item_t'(res_rdata);

endmodule

>>> tb/kway_edge_merge_csr_builder_unit_tb.sv
// ----------------------------------------------------------------------------
// kway_edge_merge_csr_builder_unit_tb
// self-checking bench for the k-way edge merge to csr builder: a directed
// table of requests followed by phases of sorted-run traffic with noise,
// each accepted request run through a local csr model and every result
// compared field by field, in order, against what that model predicts
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kway_edge_merge_csr_builder_unit_tb;

  localparam int unsigned RUNS        = 8;
  // quiet cycles before a register write and at the end of the run
  localparam int          SETTLE_CYC  = 40;
  // watchdog limit, counted in clock cycles
  localparam int          CYCLE_LIMIT = 500000;
  localparam logic [30:0] MAXV        = kemcsr_pkg::DEG_MAX;
  localparam logic        CMD_LD      = kemcsr_pkg::CMD_LOAD;
  localparam logic        CMD_EX      = kemcsr_pkg::CMD_EXHAUST;

  // one row of the directed table: a register write or a request
  typedef struct packed {
    bit                    is_cfg;
    logic [3:0]            cfg_val;
    kemcsr_pkg::in_item_t  item;
    bit                    typed;
    kemcsr_pkg::out_item_t want;
  } dir_row_t;

  // clock, reset and dut drive
  logic                  clk_i     = 1'b0;
  logic                  rst_ni    = 1'b0;
  logic                  push      = 1'b0;
  logic                  full;
  kemcsr_pkg::in_item_t  item      = '0;
  logic                  empty;
  logic                  pop       = 1'b0;
  kemcsr_pkg::out_item_t result_o;
  logic                  cfg_we    = 1'b0;
  logic [3:0]            cfg_wdata = '0;

  // csr model state
  logic [30:0] hd_src [RUNS];
  logic [30:0] hd_dst [RUNS];
  bit [RUNS-1:0] hd_full  = '0;
  bit [RUNS-1:0] run_done = '0;
  logic [31:0] prev_src  = kemcsr_pkg::NONE32;
  logic [31:0] prev_dst  = kemcsr_pkg::NONE32;
  logic [31:0] open_deg  = kemcsr_pkg::NONE32;
  logic [31:0] nbr_cnt   = '0;
  logic [31:0] deg_sum   = '0;
  logic [31:0] top_deg   = '0;
  logic [3:0]  cfg_runs  = kemcsr_pkg::ACTIVE_RUNS_RST;

  // per-run edge cursors for the sorted streams
  logic [30:0] cur_src [RUNS];
  logic [30:0] cur_dst [RUNS];

  // csr records still owed by the dut, oldest first
  kemcsr_pkg::out_item_t pending_records [$];
  dir_row_t    plan [$];
  int          fail_cnt  = 0;
  int          cyc_count = 0;
  int          burst_left = 0;

  // random phases: register value, request count, close the runs at the end
  logic [3:0]  ph_cfg   [0:5] = '{4'd15, 4'd4, 4'd8, 4'd0, 4'd6, 4'd9};
  int          ph_len   [0:5] = '{350, 250, 350, 30, 300, 270};
  bit          ph_drain [0:5] = '{1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1};

  kway_edge_merge_csr_builder_unit #(
    .MAX_RUNS(RUNS)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .item_i     (item),
    .empty      (empty),
    .pop        (pop),
    .result_o   (result_o),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- helpers

  function automatic logic [30:0] rnd31();
    logic [31:0] w;
    w = $urandom();
    return w[30:0];
  endfunction

  function automatic kemcsr_pkg::out_item_t mk_err();
    kemcsr_pkg::out_item_t r;
    r = '0;
    r.kind = kemcsr_pkg::KIND_ERROR;
    return r;
  endfunction

  function automatic kemcsr_pkg::out_item_t mk_sum(logic [31:0] vc, logic [31:0] ec,
                                                   logic [30:0] md);
    kemcsr_pkg::out_item_t r;
    r = '0;
    r.kind         = kemcsr_pkg::KIND_SUMMARY;
    r.vertex_count = vc;
    r.edge_count   = ec;
    r.peak_degree  = md;
    return r;
  endfunction

  function automatic kemcsr_pkg::out_item_t mk_merge(bit nv, logic [30:0] nbr, bit newv,
                                                     logic [31:0] off, bit pv,
                                                     logic [30:0] pd);
    kemcsr_pkg::out_item_t r;
    r = '0;
    r.kind              = kemcsr_pkg::KIND_MERGE;
    r.neighbor_valid    = nv;
    r.neighbor          = nbr;
    r.vertex_start      = newv;
    r.vertex_offset     = off;
    r.prev_degree_valid = pv;
    r.prev_degree       = pd;
    return r;
  endfunction

  // register value clamped to 1..RUNS
  function automatic int eff_runs();
    if (cfg_runs == 4'd0) return 1;
    if (cfg_runs > 4'(RUNS)) return RUNS;
    return int'(cfg_runs);
  endfunction

  // csr model: applies one accepted request, returns 1 with the record it causes
  function automatic bit predict_record(input kemcsr_pkg::in_item_t it,
                                        output kemcsr_pkg::out_item_t r);
    int          n;
    int          best;
    bit          waiting;
    logic [31:0] u;
    logic [31:0] v;
    logic [31:0] sum;
    logic [31:0] mx;
    bit          pv;
    logic [30:0] pd;
    n       = eff_runs();
    best    = -1;
    waiting = 1'b0;
    r       = '0;
    // out of range, busy or exhausted slot: error, no state change
    if (it.run >= n || hd_full[it.run] || run_done[it.run]) begin
      r = mk_err();
      return 1'b1;
    end
    if (it.cmd == CMD_LD) begin
      hd_src[it.run]  = it.src;
      hd_dst[it.run]  = it.dst;
      hd_full[it.run] = 1'b1;
    end else begin
      run_done[it.run] = 1'b1;
    end
    for (int i = 0; i < n; i++) begin
      if (!hd_full[i] && !run_done[i]) waiting = 1'b1;
      if (hd_full[i]) begin
        if (best < 0 || hd_src[i] < hd_src[best] ||
            (hd_src[i] == hd_src[best] && hd_dst[i] < hd_dst[best])) begin
          best = i;
        end
      end
    end
    if (waiting) return 1'b0;
    if (best < 0) begin
      // every active run exhausted: summary folds in the open degree only
      sum = deg_sum;
      mx  = top_deg;
      if (open_deg != kemcsr_pkg::NONE32) begin
        sum = sum + open_deg;
        if (open_deg > mx) mx = open_deg;
      end
      r = mk_sum(prev_src + 32'd1, sum >> 1, mx[30:0]);
      return 1'b1;
    end
    u = {1'b0, hd_src[best]};
    v = {1'b0, hd_dst[best]};
    hd_full[best] = 1'b0;
    if (u != prev_src) begin
      // new source vertex closes the open one
      pv = (open_deg != kemcsr_pkg::NONE32);
      pd = pv ? open_deg[30:0] : 31'd0;
      r  = mk_merge(1'b1, v[30:0], 1'b1, nbr_cnt, pv, pd);
      if (pv) begin
        deg_sum = deg_sum + open_deg;
        if (open_deg > top_deg) top_deg = open_deg;
      end
      open_deg = 32'd1;
      nbr_cnt  = nbr_cnt + 32'd1;
    end else if (v != prev_dst) begin
      r = mk_merge(1'b1, v[30:0], 1'b0, 32'd0, 1'b0, 31'd0);
      if (open_deg == kemcsr_pkg::NONE32) open_deg = 32'd1;
      else if (open_deg < {1'b0, kemcsr_pkg::DEG_MAX}) open_deg = open_deg + 32'd1;
      nbr_cnt = nbr_cnt + 32'd1;
    end else begin
      // exact repeat of the last edge is dropped
      r = mk_merge(1'b0, v[30:0], 1'b0, 32'd0, 1'b0, 31'd0);
    end
    prev_src = u;
    prev_dst = v;
    return 1'b1;
  endfunction

  // random run that wants an edge (want_needy) or one that must give an error
  function automatic int pick_run(bit want_needy);
    int cand [$];
    int n;
    bit needy;
    n = eff_runs();
    for (int i = 0; i < RUNS; i++) begin
      needy = (i < n) && !hd_full[i] && !run_done[i];
      if (needy == want_needy) cand.insert(cand.size(), i);
    end
    if (cand.size() == 0) return -1;
    return cand[$urandom_range(0, cand.size() - 1)];
  endfunction

  // next edge of one run: mostly small ascending steps so runs overlap, with a rare random jump
  task automatic next_edge(input int r, output logic [30:0] s, output logic [30:0] d);
    int          sel;
    logic [31:0] step;
    sel = $urandom_range(0, 99);
    if (sel < 3) begin
      cur_src[r] = rnd31();
      cur_dst[r] = rnd31();
    end else if (sel < 35) begin
      step       = $urandom_range(1, 3);
      cur_src[r] = cur_src[r] + step[30:0];
      step       = $urandom_range(0, 7);
      cur_dst[r] = ($urandom_range(0, 9) == 0) ? rnd31() : step[30:0];
    end else begin
      step       = $urandom_range(0, 2);
      cur_dst[r] = cur_dst[r] + step[30:0];
    end
    s = cur_src[r];
    d = cur_dst[r];
  endtask

  task automatic seed_runs();
    int          sel;
    logic [30:0] base;
    sel  = $urandom_range(0, 2);
    base = (sel == 0) ? 31'd0 : (sel == 1) ? rnd31() : 31'h7FFF_FFE0;
    for (int i = 0; i < RUNS; i++) begin
      cur_src[i] = base;
      cur_dst[i] = '0;
    end
  endtask

  // mostly refills of a waiting run, the rest aimed at a run that must fail if one exists
  task automatic gen_item(output kemcsr_pkg::in_item_t it);
    int          r;
    logic [31:0] w;
    logic [30:0] s;
    logic [30:0] d;
    it = '0;
    r  = pick_run(1'b1);
    if (r >= 0 && $urandom_range(0, 99) < 88) begin
      next_edge(r, s, d);
      it.cmd = CMD_LD;
      it.run = r[2:0];
      it.src = s;
      it.dst = d;
    end else begin
      if (pick_run(1'b0) >= 0) r = pick_run(1'b0);
      w      = $urandom();
      it.cmd = (r == pick_run(1'b0) || pick_run(1'b1) < 0) ? w[0] : CMD_LD;
      it.run = r[2:0];
      it.src = rnd31();
      it.dst = rnd31();
      // never exhaust a live run by accident
      if (it.cmd == CMD_EX && !(it.run >= eff_runs() || hd_full[it.run] ||
          run_done[it.run])) it.cmd = CMD_LD;
    end
  endtask

  // ----------------------------------------------------------- drive tasks

  // holds one request until accepted, then books the expected record
  task automatic push_item(input kemcsr_pkg::in_item_t it, input bit typed,
                           input kemcsr_pkg::out_item_t want);
    kemcsr_pkg::out_item_t r;
    @(negedge clk_i);
    push <= 1'b1;
    item <= it;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    if (predict_record(it, r)) begin
      pending_records.insert(pending_records.size(), typed ? want : r);
    end
  endtask

  // bursts of random length with random gaps
  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 24);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
      if (gap > 0) begin
        @(negedge clk_i);
        push <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
  endtask

  // sender holds off until every record is back and the block is quiet
  task automatic settle();
    @(negedge clk_i);
    push <= 1'b0;
    while (pending_records.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic [3:0] v);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
    cfg_runs   = v;
  endtask

  // exhaust every waiting run until the summary comes out
  task automatic drain_runs();
    int                   r;
    kemcsr_pkg::in_item_t it;
    r = pick_run(1'b1);
    while (r >= 0) begin
      it     = '0;
      it.cmd = CMD_EX;
      it.run = r[2:0];
      it.src = rnd31();
      it.dst = rnd31();
      push_item(it, 1'b0, '0);
      pace();
      r = pick_run(1'b1);
    end
  endtask

  function automatic dir_row_t req(logic c, logic [2:0] rn, logic [30:0] s,
                                   logic [30:0] d, bit typed,
                                   kemcsr_pkg::out_item_t want);
    dir_row_t row;
    row          = '0;
    row.item.cmd = c;
    row.item.run = rn;
    row.item.src = s;
    row.item.dst = d;
    row.typed    = typed;
    row.want     = want;
    return row;
  endfunction

  function automatic dir_row_t cfg_row(logic [3:0] v);
    dir_row_t row;
    row         = '0;
    row.is_cfg  = 1'b1;
    row.cfg_val = v;
    return row;
  endfunction

  function automatic void add_row(dir_row_t row);
    plan.insert(plan.size(), row);
  endfunction

  // --------------------------------------------------------------- checking

  task automatic cmp_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $display("%0t mismatch on %s: expected %h, actual %h", $time, name, want, got);
      fail_cnt++;
    end
  endtask

  task automatic check_record(input kemcsr_pkg::out_item_t got);
    kemcsr_pkg::out_item_t want;
    if (pending_records.size() == 0) begin
      $display("%0t unexpected result: expected none, actual kind %0d", $time, got.kind);
      fail_cnt++;
    end else begin
      want = pending_records.pop_front();
      cmp_field("kind", {30'd0, want.kind}, {30'd0, got.kind});
      cmp_field("neighbor_valid", {31'd0, want.neighbor_valid}, {31'd0, got.neighbor_valid});
      cmp_field("neighbor", {1'b0, want.neighbor}, {1'b0, got.neighbor});
      cmp_field("vertex_start", {31'd0, want.vertex_start}, {31'd0, got.vertex_start});
      cmp_field("vertex_offset", want.vertex_offset, got.vertex_offset);
      cmp_field("prev_degree_valid", {31'd0, want.prev_degree_valid},
                {31'd0, got.prev_degree_valid});
      cmp_field("prev_degree", {1'b0, want.prev_degree}, {1'b0, got.prev_degree});
      cmp_field("vertex_count", want.vertex_count, got.vertex_count);
      cmp_field("edge_count", want.edge_count, got.edge_count);
      cmp_field("peak_degree", {1'b0, want.peak_degree}, {1'b0, got.peak_degree});
    end
  endtask

  // receiver: checks at the rising edge, changes pop at the falling edge
  initial begin
    int mode;
    int mode_left;
    int hold;
    mode      = 0;
    mode_left = 0;
    hold      = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && pop && !empty) check_record(result_o);
      @(negedge clk_i);
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(64, 256);
      end
      mode_left--;
      case (mode)
        0: begin
          pop <= 1'b1;
        end
        1: begin
          pop <= ($urandom_range(0, 1) == 1);
        end
        2: begin
          pop <= (cyc_count % 5 != 0);
        end
        default: begin
          // long stalls with a single pop between them
          if (hold > 0) begin
            hold--;
            pop <= 1'b0;
          end else begin
            hold = $urandom_range(10, 40);
            pop <= 1'b1;
          end
        end
      endcase
    end
  end

  // watchdog
  initial begin
    while (cyc_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cyc_count++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  // ----------------------------------------------------------------- sender
  initial begin
    kemcsr_pkg::in_item_t it;

    // directed table
    // busy slot on a full head, for a load and for an exhaust mark
    add_row(req(CMD_LD, 3'd3, 31'd5, 31'd7, 1'b0, '0));
    add_row(req(CMD_LD, 3'd3, MAXV, MAXV, 1'b1, mk_err()));
    add_row(req(CMD_EX, 3'd3, 31'd0, 31'd0, 1'b1, mk_err()));
    // one run: empty graph summary, then requests to a dead run
    add_row(cfg_row(4'd1));
    add_row(req(CMD_EX, 3'd0, MAXV, 31'd0, 1'b1, mk_sum(32'd0, 32'd0, 31'd0)));
    add_row(req(CMD_LD, 3'd0, 31'd0, 31'd0, 1'b1, mk_err()));
    add_row(req(CMD_EX, 3'd0, 31'd0, MAXV, 1'b1, mk_err()));
    // run index out of range
    add_row(req(CMD_LD, 3'd7, MAXV, MAXV, 1'b1, mk_err()));
    // zero acts as one run
    add_row(cfg_row(4'd0));
    add_row(req(CMD_EX, 3'd1, MAXV, MAXV, 1'b1, mk_err()));
    // two runs with run 0 dead: each load is taken at once
    add_row(cfg_row(4'd2));
    add_row(req(CMD_LD, 3'd1, 31'd0, 31'd0, 1'b1,
                mk_merge(1'b1, 31'd0, 1'b1, 32'd0, 1'b0, 31'd0)));
    // dropped repeat
    add_row(req(CMD_LD, 3'd1, 31'd0, 31'd0, 1'b1,
                mk_merge(1'b0, 31'd0, 1'b0, 32'd0, 1'b0, 31'd0)));
    add_row(req(CMD_LD, 3'd1, 31'd0, MAXV, 1'b1,
                mk_merge(1'b1, MAXV, 1'b0, 32'd0, 1'b0, 31'd0)));
    add_row(req(CMD_LD, 3'd1, MAXV, 31'd0, 1'b1,
                mk_merge(1'b1, 31'd0, 1'b1, 32'd2, 1'b1, 31'd2)));
    add_row(req(CMD_LD, 3'd1, MAXV, MAXV, 1'b0, '0));
    // summary at the largest source vertex
    add_row(req(CMD_EX, 3'd1, 31'd0, 31'd0, 1'b1, mk_sum(32'h8000_0000, 32'd2, 31'd2)));
    add_row(req(CMD_LD, 3'd1, 31'd5, 31'd5, 1'b1, mk_err()));

    // reset, once
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    settle();

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        settle();
        write_cfg(plan[i].cfg_val);
      end else begin
        push_item(plan[i].item, plan[i].typed, plan[i].want);
        pace();
      end
    end

    // random phases over several run counts, later summaries stay cumulative
    for (int p = 0; p < 6; p++) begin
      settle();
      write_cfg(ph_cfg[p]);
      seed_runs();
      for (int k = 0; k < ph_len[p]; k++) begin
        gen_item(it);
        push_item(it, 1'b0, '0);
        if ($urandom_range(0, 199) == 0) settle();
        else pace();
      end
      if (ph_drain[p]) drain_runs();
    end

    // wait for the last records, then let the block go quiet
    @(negedge clk_i);
    push <= 1'b0;
    while (pending_records.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/kemcsr_pkg.sv
rtl/core/kemcsr_fifo.sv
rtl/core/kemcsr_front.sv
rtl/core/kemcsr_back.sv
rtl/core/kway_edge_merge_csr_builder_unit.sv
tb/kway_edge_merge_csr_builder_unit_tb.sv
